// File: rtl/core/rau_pkg.sv
// Shared constants, codes and types of the rational arithmetic unit.
package rau_pkg;

  // Operand width taken from each 32-bit input field, as two's complement.
  localparam int OPERAND_BITS = 32;
  localparam int MAG_W        = OPERAND_BITS;
  localparam int WORK_W       = 2 * OPERAND_BITS;
  localparam int SHIFT_W      = $clog2(WORK_W);

  // Fixed field widths of the stream payloads.
  localparam int FIELD_W     = 32;
  localparam int REQ_TYPE_W  = 3;
  localparam int RES_NUM_W   = 64;
  localparam int RES_DEN_W   = 63;
  localparam int STATUS_W    = 2;
  localparam int FLAGS_W     = 3;
  localparam int IN_DATA_W   = 4 * FIELD_W;
  localparam int OUT_USED_W  = RES_NUM_W + RES_DEN_W + FLAGS_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

  // Request types.
  localparam logic [REQ_TYPE_W-1:0] OP_ADD = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] OP_SUB = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] OP_MUL = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] OP_DIV = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] OP_CMP = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Largest magnitudes of a signed 64-bit result.
  localparam logic [RES_NUM_W-1:0] MAX_POS = {1'b0, {(RES_NUM_W-1){1'b1}}};
  localparam logic [RES_NUM_W-1:0] MAX_NEG = {1'b1, {(RES_NUM_W-1){1'b0}}};

  // Positions of the compare flags.
  localparam int FLAG_LT = 0;
  localparam int FLAG_EQ = 1;
  localparam int FLAG_GT = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_PREP,
    ST_GCD,
    ST_DIV,
    ST_NORM,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit: sequenced multiply, binary GCD and exact division.
// Sequence: a request is latched and its products are formed in turn (ST_MUL); compare and
// error requests then go from ST_EVAL to ST_DONE, zero or overflowing arithmetic results from
// ST_PREP; other arithmetic runs the binary GCD loop, the restoring divider and ST_NORM first.
// One request is in flight at a time; the next is taken the cycle after the result is registered.
// rst (synchronous, active high) clears the sequencer and the output valid flag.
module rational_arithmetic_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // num_a [31:0], den_a [63:32], num_b [95:64], den_b [127:96]
  input  logic [rau_pkg::IN_DATA_W-1:0]         s_tdata,
  // req_type [2:0]
  input  logic [rau_pkg::REQ_TYPE_W-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // res_num [63:0], res_den [126:64], is_less [127], is_equal [128],
  // is_greater [129], zero padding [135:130]
  output logic [rau_pkg::OUT_DATA_W-1:0]        m_tdata,
  // status [1:0]
  output logic [rau_pkg::STATUS_W-1:0]          m_tuser
);

  localparam int MW = rau_pkg::MAG_W;
  localparam int WW = rau_pkg::WORK_W;
  localparam int SW = rau_pkg::SHIFT_W;
  localparam int FW = rau_pkg::FIELD_W;

  rau_pkg::state_t state, state_next;

  // Latched request.
  logic [rau_pkg::REQ_TYPE_W-1:0] op;
  logic [MW-1:0] mag_na, mag_da, mag_nb, mag_db;
  logic          sgn_na, sgn_da, sgn_nb, sgn_db;

  // Multiplier sequencing and products.
  logic [1:0]    mul_idx;
  logic [MW-1:0] mul_a, mul_b;
  logic [WW-1:0] mul_p;
  logic [WW-1:0] prod0, prod1, prod2;

  // GCD and division working registers.
  logic [WW-1:0] gx, gy, nmag, dmag, gdiv;
  logic [SW-1:0] kshift;
  logic          neg;
  logic [WW-1:0] quo_n, quo_d, rem_n, rem_d;
  logic [SW-1:0] div_cnt;

  // Result held until the output register is free.
  logic [rau_pkg::RES_NUM_W-1:0] rnum;
  logic [rau_pkg::RES_DEN_W-1:0] rden;
  logic [rau_pkg::FLAGS_W-1:0]   rflags;
  logic [rau_pkg::STATUS_W-1:0]  rstatus;

  logic [rau_pkg::RES_NUM_W-1:0] out_num;
  logic [rau_pkg::RES_DEN_W-1:0] out_den;
  logic [rau_pkg::FLAGS_W-1:0]   out_flags;
  logic [rau_pkg::STATUS_W-1:0]  out_status;

  // Operand extraction.
  logic [MW-1:0] fld_na, fld_da, fld_nb, fld_db;
  assign fld_na = s_tdata[0*FW +: MW];
  assign fld_da = s_tdata[1*FW +: MW];
  assign fld_nb = s_tdata[2*FW +: MW];
  assign fld_db = s_tdata[3*FW +: MW];

  // Control strobes.
  logic accept, load_out, err, addsub, gcd_exit, ovf;

  // Evaluation logic.
  logic          s1, s2, s2e, dneg, sp, sq, mag_lt, mag_eq;
  logic          p_lt_q, p_eq_q, p_gt_q, cmp_lt, cmp_gt;
  logic [rau_pkg::FLAGS_W-1:0] cmp_flags;
  logic [WW-1:0] sum;
  logic [WW:0]   diff;
  logic          ge;
  logic [WW-1:0] smag;
  logic          sneg;

  // GCD and division step logic.
  logic [WW:0]   sub_xy, sub_yx;
  logic [WW:0]   r2_n, r2_d;
  logic [WW+1:0] t_n, t_d;
  logic          fit_n, fit_d;

  always_comb begin
    unique case (mul_idx)
      2'd0: begin
        mul_a = mag_na;
        mul_b = (op == rau_pkg::OP_MUL) ? mag_nb : mag_db;
      end
      2'd1: begin
        mul_a = (op == rau_pkg::OP_MUL) ? mag_da : mag_nb;
        mul_b = (op == rau_pkg::OP_MUL) ? mag_db : mag_da;
      end
      default: begin
        mul_a = mag_da;
        mul_b = mag_db;
      end
    endcase
  end

  assign mul_p = WW'(mul_a) * WW'(mul_b);

  // Sign/magnitude compare of the two cross products, then flipped when the
  // denominators disagree in sign.
  assign s1     = sgn_na ^ sgn_db;
  assign s2     = sgn_nb ^ sgn_da;
  assign dneg   = sgn_da ^ sgn_db;
  assign sp     = s1 && (prod0 != '0);
  assign sq     = s2 && (prod1 != '0);
  assign mag_lt = prod0 < prod1;
  assign mag_eq = prod0 == prod1;
  assign p_lt_q = (sp != sq) ? sp : (sp ? (!mag_lt && !mag_eq) : mag_lt);
  assign p_eq_q = (sp == sq) && mag_eq;
  assign p_gt_q = !p_lt_q && !p_eq_q;
  assign cmp_lt = dneg ? p_gt_q : p_lt_q;
  assign cmp_gt = dneg ? p_lt_q : p_gt_q;

  always_comb begin
    cmp_flags                   = '0;
    cmp_flags[rau_pkg::FLAG_LT] = cmp_lt;
    cmp_flags[rau_pkg::FLAG_EQ] = p_eq_q;
    cmp_flags[rau_pkg::FLAG_GT] = cmp_gt;
  end

  assign addsub = (op == rau_pkg::OP_ADD) || (op == rau_pkg::OP_SUB);
  assign s2e    = s2 ^ (op == rau_pkg::OP_SUB);
  assign sum    = prod0 + prod1;
  assign diff   = {1'b0, prod0} - {1'b0, prod1};
  assign ge     = !diff[WW];

  always_comb begin
    if (s1 == s2e) begin
      smag = sum;
      sneg = s1;
    end else if (ge) begin
      smag = diff[WW-1:0];
      sneg = s1;
    end else begin
      smag = WW'(0) - diff[WW-1:0];
      sneg = s2e;
    end
    if (smag == '0) begin
      sneg = 1'b0;
    end
  end

  assign err = (op > rau_pkg::OP_CMP) || (mag_da == '0) || (mag_db == '0) ||
               ((op == rau_pkg::OP_DIV) && (mag_nb == '0));

  assign ovf = addsub &&
               (rau_pkg::RES_NUM_W'(gx) > (neg ? rau_pkg::MAX_NEG : rau_pkg::MAX_POS));

  assign gcd_exit = (gx == '0) || (gy == '0);
  assign sub_xy   = {1'b0, gx} - {1'b0, gy};
  assign sub_yx   = {1'b0, gy} - {1'b0, gx};

  // Restoring division, numerator and denominator lanes side by side.
  assign r2_n  = {rem_n, quo_n[WW-1]};
  assign r2_d  = {rem_d, quo_d[WW-1]};
  assign t_n   = {1'b0, r2_n} - {2'b0, gdiv};
  assign t_d   = {1'b0, r2_d} - {2'b0, gdiv};
  assign fit_n = !t_n[WW+1];
  assign fit_d = !t_d[WW+1];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = rau_pkg::ST_MUL;
      end
      rau_pkg::ST_MUL: begin
        if (mul_idx == 2'd2) state_next = rau_pkg::ST_EVAL;
      end
      rau_pkg::ST_EVAL: begin
        if (err || (op == rau_pkg::OP_CMP)) state_next = rau_pkg::ST_DONE;
        else state_next = rau_pkg::ST_PREP;
      end
      rau_pkg::ST_PREP: begin
        if (ovf || (gx == '0)) state_next = rau_pkg::ST_DONE;
        else state_next = rau_pkg::ST_GCD;
      end
      rau_pkg::ST_GCD: begin
        if (gcd_exit) state_next = rau_pkg::ST_DIV;
      end
      rau_pkg::ST_DIV: begin
        if (div_cnt == SW'(WW - 1)) state_next = rau_pkg::ST_NORM;
      end
      rau_pkg::ST_NORM: begin
        state_next = rau_pkg::ST_DONE;
      end
      rau_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = rau_pkg::ST_IDLE;
      end
      default: state_next = rau_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs and strobes.
  always_comb begin
    s_tready = (state == rau_pkg::ST_IDLE);
    accept   = s_tready && s_tvalid;
    load_out = (state == rau_pkg::ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rau_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= s_tuser;
      sgn_na  <= fld_na[MW-1];
      sgn_da  <= fld_da[MW-1];
      sgn_nb  <= fld_nb[MW-1];
      sgn_db  <= fld_db[MW-1];
      mag_na  <= fld_na[MW-1] ? (MW'(0) - fld_na) : fld_na;
      mag_da  <= fld_da[MW-1] ? (MW'(0) - fld_da) : fld_da;
      mag_nb  <= fld_nb[MW-1] ? (MW'(0) - fld_nb) : fld_nb;
      mag_db  <= fld_db[MW-1] ? (MW'(0) - fld_db) : fld_db;
      mul_idx <= 2'd0;
    end

    unique case (state)
      rau_pkg::ST_MUL: begin
        unique case (mul_idx)
          2'd0:    prod0 <= mul_p;
          2'd1:    prod1 <= mul_p;
          default: prod2 <= mul_p;
        endcase
        mul_idx <= mul_idx + 2'd1;
      end
      rau_pkg::ST_EVAL: begin
        rnum <= '0;
        rden <= rau_pkg::RES_DEN_W'(1);
        if (err) begin
          rflags  <= '0;
          rstatus <= rau_pkg::STATUS_ZERO_DEN;
        end else if (op == rau_pkg::OP_CMP) begin
          rflags  <= cmp_flags;
          rstatus <= rau_pkg::STATUS_OK;
        end else begin
          rflags  <= '0;
          rstatus <= rau_pkg::STATUS_OK;
          gx      <= addsub ? smag : prod0;
          gy      <= addsub ? prod2 : prod1;
          neg     <= addsub ? sneg : (sgn_na ^ sgn_da ^ sgn_nb ^ sgn_db);
        end
      end
      rau_pkg::ST_PREP: begin
        if (ovf) begin
          rstatus <= rau_pkg::STATUS_OVERFLOW;
        end
        nmag   <= gx;
        dmag   <= gy;
        kshift <= '0;
        neg    <= neg ^ (addsub & dneg);
      end
      rau_pkg::ST_GCD: begin
        if (gcd_exit) begin
          gdiv    <= gx | gy;
          quo_n   <= nmag >> kshift;
          quo_d   <= dmag >> kshift;
          rem_n   <= '0;
          rem_d   <= '0;
          div_cnt <= '0;
        end else if (!gx[0] && !gy[0]) begin
          gx     <= gx >> 1;
          gy     <= gy >> 1;
          kshift <= kshift + SW'(1);
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (!sub_xy[WW]) begin
          gx <= sub_xy[WW:1];
        end else begin
          gy <= sub_yx[WW:1];
        end
      end
      rau_pkg::ST_DIV: begin
        rem_n   <= fit_n ? t_n[WW-1:0] : r2_n[WW-1:0];
        rem_d   <= fit_d ? t_d[WW-1:0] : r2_d[WW-1:0];
        quo_n   <= {quo_n[WW-2:0], fit_n};
        quo_d   <= {quo_d[WW-2:0], fit_d};
        div_cnt <= div_cnt + SW'(1);
      end
      rau_pkg::ST_NORM: begin
        rnum <= neg ? (rau_pkg::RES_NUM_W'(0) - rau_pkg::RES_NUM_W'(quo_n))
                    : rau_pkg::RES_NUM_W'(quo_n);
        rden <= rau_pkg::RES_DEN_W'(quo_d);
      end
      default: begin
      end
    endcase

    if (load_out) begin
      out_num    <= rnum;
      out_den    <= rden;
      out_flags  <= rflags;
      out_status <= rstatus;
    end
  end

  assign m_tdata = {{rau_pkg::OUT_PAD_W{1'b0}}, out_flags, out_den, out_num};
  assign m_tuser = out_status;

  // The GCD loop is entered with both values nonzero, so they never vanish together.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == rau_pkg::ST_GCD) |-> ((gx != '0) || (gy != '0)))
    else $error("GCD operands both zero");

  // The odd part of the divisor is what the divider works with.
  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    (state == rau_pkg::ST_DIV) |-> gdiv[0])
    else $error("Divisor is not odd");

  // A result denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[rau_pkg::RES_NUM_W +: rau_pkg::RES_DEN_W] != '0))
    else $error("Zero result denominator");

  // At most one compare flag is raised.
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[rau_pkg::RES_NUM_W + rau_pkg::RES_DEN_W +: rau_pkg::FLAGS_W]))
    else $error("Several compare flags set");

  // A request always starts the multiply sequence.
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == rau_pkg::ST_MUL) && (mul_idx == 2'd0))
    else $error("Request did not start the multiply sequence");

endmodule
